>>> sv/flk_pkg.sv
// shared types, constants and arithmetic helpers for the leg kinematics block
package flk_pkg;

  localparam int ANGLE_BITS_DEFAULT = 16;
  localparam int TRIG_ITERATIONS_DEFAULT = 16;
  localparam int QUEUE_DEPTH = 4;

  localparam int SUM_W = 18;
  localparam int RATE_W = 16;
  localparam int LEN_W = 16;
  localparam int TRIG_W = 18;
  localparam int CORDIC_W = 34;
  localparam int TERM_W = LEN_W + 1 + TRIG_W;
  localparam int ENT_W = TERM_W + 2;
  localparam int PROD_W = ENT_W + RATE_W;
  localparam int VEL_SUM_W = PROD_W + 3;
  localparam int POS_OUT_W = 20;
  localparam int VEL_OUT_W = 24;
  localparam int CFG_ADDR_W = 3;

  localparam logic signed [47:0] TURN_SCALE = 48'sd683565276;
  localparam logic signed [CORDIC_W-1:0] CORDIC_X0 = 34'sd652032874;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_WHOLE_BODY  = 3'd0,
    CFG_LEFT_THIGH  = 3'd1,
    CFG_LEFT_SHANK  = 3'd2,
    CFG_RIGHT_THIGH = 3'd3,
    CFG_RIGHT_SHANK = 3'd4
  } cfg_addr_t;

  typedef struct packed {
    logic              whole_body;
    logic [LEN_W-1:0]  l_thigh;
    logic [LEN_W-1:0]  l_shank;
    logic [LEN_W-1:0]  r_thigh;
    logic [LEN_W-1:0]  r_shank;
  } cfg_t;

  typedef struct packed {
    logic signed [SUM_W-1:0]  sum_b1;
    logic signed [SUM_W-1:0]  sum_b12;
    logic signed [SUM_W-1:0]  sum_b3;
    logic signed [SUM_W-1:0]  sum_b34;
    logic signed [RATE_W-1:0] rate_b;
    logic signed [RATE_W-1:0] rate_lh;
    logic signed [RATE_W-1:0] rate_lk;
    logic signed [RATE_W-1:0] rate_rh;
    logic signed [RATE_W-1:0] rate_rk;
  } item_t;

  typedef struct packed {
    logic [VEL_OUT_W-1:0] rvy;
    logic [VEL_OUT_W-1:0] rvx;
    logic [VEL_OUT_W-1:0] lvy;
    logic [VEL_OUT_W-1:0] lvx;
    logic [POS_OUT_W-1:0] ry;
    logic [POS_OUT_W-1:0] rx;
    logic [POS_OUT_W-1:0] ly;
    logic [POS_OUT_W-1:0] lx;
  } result_t;

  function automatic logic signed [CORDIC_W-1:0] atan_entry(input int i);
    logic signed [CORDIC_W-1:0] v;
    case (i)
      0: v = 34'sd536870912;
      1: v = 34'sd316933406;
      2: v = 34'sd167458907;
      3: v = 34'sd85004756;
      4: v = 34'sd42667331;
      5: v = 34'sd21354465;
      6: v = 34'sd10680862;
      7: v = 34'sd5340245;
      8: v = 34'sd2670163;
      9: v = 34'sd1335087;
      10: v = 34'sd667544;
      11: v = 34'sd333772;
      12: v = 34'sd166886;
      13: v = 34'sd83443;
      14: v = 34'sd41721;
      15: v = 34'sd20860;
      16: v = 34'sd10430;
      17: v = 34'sd5215;
      18: v = 34'sd2607;
      19: v = 34'sd1303;
      20: v = 34'sd651;
      21: v = 34'sd325;
      22: v = 34'sd162;
      23: v = 34'sd81;
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic logic [POS_OUT_W-1:0] sat_pos(input logic signed [ENT_W-1:0] v);
    logic signed [ENT_W-1:0] r;
    logic [POS_OUT_W-1:0] o;
    r = (v + 37'sd16384) >>> 15;
    if (r > 37'sd524287) o = 20'h7FFFF;
    else if (r < -37'sd524288) o = 20'h80000;
    else o = r[POS_OUT_W-1:0];
    return o;
  endfunction

  function automatic logic [VEL_OUT_W-1:0] sat_vel(input logic signed [VEL_SUM_W-1:0] v);
    logic signed [VEL_SUM_W-1:0] r;
    logic [VEL_OUT_W-1:0] o;
    r = (v + (56'sd1 <<< 24)) >>> 25;
    if (r > 56'sd8388607) o = 24'h7FFFFF;
    else if (r < -56'sd8388608) o = 24'h800000;
    else o = r[VEL_OUT_W-1:0];
    return o;
  endfunction

endpackage

>>> sv/planar_leg_forward_kinematics.sv
// top level of the planar leg forward kinematics block
//
//  channel   direction  payload
//  s_axis    in         ten 16-bit joint angles and rates
//  m_axis    out        four 20-bit ankle positions, four 24-bit ankle velocities
//  cfg       in         mode flag and four link lengths, write only
//
//  one transaction per cycle sustained while m_axis is not stalled; the pipeline depth is
//  set mostly by the cordic stages of the four trig lanes
//  rst is synchronous and clears all valid flags and the configuration registers
//  a stall on m_axis freezes the arithmetic pipeline; the input stage and a four-entry
//  queue keep taking transactions until the queue fills
module planar_leg_forward_kinematics
  import flk_pkg::*;
#(
  parameter int ANGLE_BITS = ANGLE_BITS_DEFAULT,
  parameter int TRIG_ITERATIONS = TRIG_ITERATIONS_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // base_angle, left_hip_angle, left_knee_angle, right_hip_angle, right_knee_angle,
  // base_rate, left_hip_rate, left_knee_rate, right_hip_rate, right_knee_rate
  input  logic [159:0]          s_axis_tdata,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // left_ankle_x, left_ankle_y, right_ankle_x, right_ankle_y,
  // left_ankle_vx, left_ankle_vy, right_ankle_vx, right_ankle_vy
  output logic [175:0]          m_axis_tdata,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [LEN_W-1:0]      cfg_wdata
);

  cfg_t    cfg;
  logic    push, queue_full, queue_empty, pop;
  item_t   front_item;
  logic [$bits(item_t)-1:0] head_bits;
  result_t result;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_WHOLE_BODY:  cfg.whole_body <= cfg_wdata[0];
        CFG_LEFT_THIGH:  cfg.l_thigh <= cfg_wdata;
        CFG_LEFT_SHANK:  cfg.l_shank <= cfg_wdata;
        CFG_RIGHT_THIGH: cfg.r_thigh <= cfg_wdata;
        CFG_RIGHT_SHANK: cfg.r_shank <= cfg_wdata;
        default: ;
      endcase
    end
  end

  flk_front u_front (
    .clk(clk), .rst(rst),
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_data(s_axis_tdata),
    .push(push), .queue_full(queue_full), .item(front_item)
  );

  flk_queue #(.WIDTH($bits(item_t)), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk(clk), .rst(rst),
    .push(push), .push_data(front_item),
    .pop(pop), .head(head_bits),
    .full(queue_full), .empty(queue_empty)
  );

  flk_back #(.ANGLE_BITS(ANGLE_BITS), .TRIG_ITERATIONS(TRIG_ITERATIONS)) u_back (
    .clk(clk), .rst(rst), .cfg(cfg),
    .queue_empty(queue_empty), .head(item_t'(head_bits)), .pop(pop),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .result(result)
  );

  assign m_axis_tdata = result;

endmodule

>>> sv/flk_front.sv
// input stage: takes a transaction and forms the link angle sums
module flk_front
  import flk_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  logic [159:0] in_data,
  output logic         push,
  input  logic         queue_full,
  output item_t        item
);

  logic  front_valid;
  logic  front_valid_next;
  item_t item_next;
  logic  take;
  logic signed [SUM_W-1:0] tb, t1, t2, t3, t4;

  assign push = front_valid && !queue_full;
  assign in_ready = !front_valid || !queue_full;
  assign take = in_valid && in_ready;

  always_comb begin
    tb = SUM_W'($signed(in_data[15:0]));
    t1 = SUM_W'($signed(in_data[31:16]));
    t2 = SUM_W'($signed(in_data[47:32]));
    t3 = SUM_W'($signed(in_data[63:48]));
    t4 = SUM_W'($signed(in_data[79:64]));
    item_next.sum_b1  = tb + t1;
    item_next.sum_b12 = tb + t1 + t2;
    item_next.sum_b3  = tb + t3;
    item_next.sum_b34 = tb + t3 + t4;
    item_next.rate_b  = $signed(in_data[95:80]);
    item_next.rate_lh = $signed(in_data[111:96]);
    item_next.rate_lk = $signed(in_data[127:112]);
    item_next.rate_rh = $signed(in_data[143:128]);
    item_next.rate_rk = $signed(in_data[159:144]);
  end

  always_comb begin
    front_valid_next = front_valid;
    if (take) front_valid_next = 1'b1;
    else if (push) front_valid_next = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) front_valid <= 1'b0;
    else front_valid <= front_valid_next;
  end

  always_ff @(posedge clk) begin
    if (take) item <= item_next;
  end

endmodule

>>> sv/flk_queue.sv
// short queue between the input stage and the arithmetic pipeline
module flk_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] head,
  output logic             full,
  output logic             empty
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count, count_next;

  assign full = (count == CNT_W'(DEPTH));
  assign empty = (count == '0);
  assign head = mem[rd_ptr];

  always_comb begin
    count_next = count;
    if (push && !pop) count_next = count + 1'b1;
    else if (pop && !push) count_next = count - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_data;
  end

  a_no_underflow: assert property (@(posedge clk) disable iff (rst) !(pop && empty))
    else $error("queue read while empty");
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) !(push && full && !pop))
    else $error("queue written while full");
  a_count_track: assert property (@(posedge clk) disable iff (rst)
    (push && !pop && !full) |=> (count == $past(count) + 1'b1))
    else $error("queue count lost a write");

endmodule

>>> sv/flk_trig.sv
// pipelined phase scaling and cordic rotation giving rounded cosine and sine
module flk_trig
  import flk_pkg::*;
#(
  parameter int ANGLE_BITS = ANGLE_BITS_DEFAULT,
  parameter int TRIG_ITERATIONS = TRIG_ITERATIONS_DEFAULT
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic signed [SUM_W-1:0]  angle,
  output logic signed [TRIG_W-1:0] cs,
  output logic signed [TRIG_W-1:0] sn
);

  localparam int A = ANGLE_BITS;
  localparam int N = TRIG_ITERATIONS;

  logic signed [47:0] prod;
  logic [A-1:0] p, p_rnd, ru;
  logic [1:0] q;
  logic signed [CORDIC_W-1:0] z0;
  logic signed [CORDIC_W-1:0] x_s [N+1];
  logic signed [CORDIC_W-1:0] y_s [N+1];
  logic signed [CORDIC_W-1:0] z_s [N+1];
  logic [1:0] q_s [N+1];
  logic signed [CORDIC_W-1:0] xr, yr, xo, yo;

  always_ff @(posedge clk) begin
    if (en) prod <= 48'(angle) * TURN_SCALE + (48'sd1 <<< (43 - A));
  end

  always_comb begin
    p = prod[44-A +: A];
    p_rnd = p + (A'(1) << (A - 3));
    q = p_rnd[A-1:A-2];
    ru = p - {q, (A-2)'(0)};
    z0 = CORDIC_W'($signed(ru)) <<< (32 - A);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_s[0] <= CORDIC_X0;
      y_s[0] <= '0;
      z_s[0] <= z0;
      q_s[0] <= q;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_iter
    always_ff @(posedge clk) begin
      if (en) begin
        q_s[i+1] <= q_s[i];
        if (z_s[i] >= 0) begin
          x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
          y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
          z_s[i+1] <= z_s[i] - atan_entry(i);
        end else begin
          x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
          y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
          z_s[i+1] <= z_s[i] + atan_entry(i);
        end
      end
    end
  end

  always_comb begin
    unique case (q_s[N])
      2'd0: begin xr = x_s[N];  yr = y_s[N];  end
      2'd1: begin xr = -y_s[N]; yr = x_s[N];  end
      2'd2: begin xr = -x_s[N]; yr = -y_s[N]; end
      default: begin xr = y_s[N]; yr = -x_s[N]; end
    endcase
    xo = (xr + 34'sd16384) >>> 15;
    yo = (yr + 34'sd16384) >>> 15;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cs <= xo[TRIG_W-1:0];
      sn <= yo[TRIG_W-1:0];
    end
  end

endmodule

>>> sv/flk_back.sv
// arithmetic pipeline: trig lanes, link terms, jacobian rows, rate products, output register
module flk_back
  import flk_pkg::*;
#(
  parameter int ANGLE_BITS = ANGLE_BITS_DEFAULT,
  parameter int TRIG_ITERATIONS = TRIG_ITERATIONS_DEFAULT
) (
  input  logic    clk,
  input  logic    rst,
  input  cfg_t    cfg,
  input  logic    queue_empty,
  input  item_t   head,
  output logic    pop,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t result
);

  localparam int LAT = TRIG_ITERATIONS + 3;

  logic en;
  logic s0_valid;
  item_t s0;
  logic signed [TRIG_W-1:0] cs [4];
  logic signed [TRIG_W-1:0] sn [4];
  logic d_valid [LAT];
  logic signed [RATE_W-1:0] d_rate [LAT][5];

  logic t_valid;
  logic signed [TERM_W-1:0] tc [4];
  logic signed [TERM_W-1:0] ts [4];
  logic signed [RATE_W-1:0] t_rate [5];

  logic j_valid;
  logic signed [ENT_W-1:0] pos_next [4];
  logic signed [ENT_W-1:0] ent_next [4][5];
  logic signed [ENT_W-1:0] j_pos [4];
  logic signed [ENT_W-1:0] j_ent [4][5];
  logic signed [RATE_W-1:0] j_rate [5];

  logic v_valid;
  logic signed [ENT_W-1:0] v_pos [4];
  logic signed [PROD_W-1:0] v_prod [4][5];
  logic signed [VEL_SUM_W-1:0] vel [4];

  logic signed [ENT_W-1:0] a1c, a2c, a3c, a4c, a1s, a2s, a3s, a4s;
  logic signed [ENT_W-1:0] lxw, lyw;
  logic wb;

  assign en = !out_valid || out_ready;
  assign pop = en && !queue_empty;

  always_ff @(posedge clk) begin
    if (rst) s0_valid <= 1'b0;
    else if (en) s0_valid <= !queue_empty;
  end

  always_ff @(posedge clk) begin
    if (pop) s0 <= head;
  end

  flk_trig #(.ANGLE_BITS(ANGLE_BITS), .TRIG_ITERATIONS(TRIG_ITERATIONS)) u_trig_1 (
    .clk(clk), .en(en), .angle(s0.sum_b1), .cs(cs[0]), .sn(sn[0]));
  flk_trig #(.ANGLE_BITS(ANGLE_BITS), .TRIG_ITERATIONS(TRIG_ITERATIONS)) u_trig_12 (
    .clk(clk), .en(en), .angle(s0.sum_b12), .cs(cs[1]), .sn(sn[1]));
  flk_trig #(.ANGLE_BITS(ANGLE_BITS), .TRIG_ITERATIONS(TRIG_ITERATIONS)) u_trig_3 (
    .clk(clk), .en(en), .angle(s0.sum_b3), .cs(cs[2]), .sn(sn[2]));
  flk_trig #(.ANGLE_BITS(ANGLE_BITS), .TRIG_ITERATIONS(TRIG_ITERATIONS)) u_trig_34 (
    .clk(clk), .en(en), .angle(s0.sum_b34), .cs(cs[3]), .sn(sn[3]));

  // rates and valid ride alongside the trig lanes
  always_ff @(posedge clk) begin
    if (rst) d_valid[0] <= 1'b0;
    else if (en) d_valid[0] <= s0_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_rate[0][0] <= s0.rate_b;
      d_rate[0][1] <= s0.rate_lh;
      d_rate[0][2] <= s0.rate_lk;
      d_rate[0][3] <= s0.rate_rh;
      d_rate[0][4] <= s0.rate_rk;
    end
  end

  for (genvar k = 1; k < LAT; k++) begin : g_delay
    always_ff @(posedge clk) begin
      if (rst) d_valid[k] <= 1'b0;
      else if (en) d_valid[k] <= d_valid[k-1];
    end
    always_ff @(posedge clk) begin
      if (en) d_rate[k] <= d_rate[k-1];
    end
  end

  // link terms
  always_ff @(posedge clk) begin
    if (rst) t_valid <= 1'b0;
    else if (en) t_valid <= d_valid[LAT-1];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tc[0] <= $signed({1'b0, cfg.l_thigh}) * cs[0];
      ts[0] <= $signed({1'b0, cfg.l_thigh}) * sn[0];
      tc[1] <= $signed({1'b0, cfg.l_shank}) * cs[1];
      ts[1] <= $signed({1'b0, cfg.l_shank}) * sn[1];
      tc[2] <= $signed({1'b0, cfg.r_thigh}) * cs[2];
      ts[2] <= $signed({1'b0, cfg.r_thigh}) * sn[2];
      tc[3] <= $signed({1'b0, cfg.r_shank}) * cs[3];
      ts[3] <= $signed({1'b0, cfg.r_shank}) * sn[3];
      t_rate <= d_rate[LAT-2+1];
    end
  end

  // positions and jacobian rows
  always_comb begin
    wb = cfg.whole_body;
    a1c = ENT_W'(tc[0]); a2c = ENT_W'(tc[1]); a3c = ENT_W'(tc[2]); a4c = ENT_W'(tc[3]);
    a1s = ENT_W'(ts[0]); a2s = ENT_W'(ts[1]); a3s = ENT_W'(ts[2]); a4s = ENT_W'(ts[3]);
    lxw = a3c - a1c - a2c + a4c;
    lyw = a3s - a1s - a2s + a4s;
    pos_next[0] = wb ? lxw : -a1c - a2c;
    pos_next[1] = wb ? lyw : -a1s - a2s;
    pos_next[2] = wb ? -lxw : -a3c - a4c;
    pos_next[3] = wb ? -lyw : -a3s - a4s;

    ent_next[0][0] = wb ? a1s - a3s + a2s - a4s : '0;
    ent_next[0][1] = a1s + a2s;
    ent_next[0][2] = a2s;
    ent_next[0][3] = wb ? -a3s - a4s : '0;
    ent_next[0][4] = wb ? -a4s : '0;

    ent_next[1][0] = wb ? -a1c + a3c - a2c + a4c : '0;
    ent_next[1][1] = -a1c - a2c;
    ent_next[1][2] = -a2c;
    ent_next[1][3] = wb ? a3c + a4c : '0;
    ent_next[1][4] = wb ? a4c : '0;

    ent_next[2][0] = wb ? -(a1s - a3s + a2s - a4s) : '0;
    ent_next[2][1] = wb ? -(a1s + a2s) : '0;
    ent_next[2][2] = wb ? -a2s : '0;
    ent_next[2][3] = a3s + a4s;
    ent_next[2][4] = a4s;

    ent_next[3][0] = wb ? -(-a1c + a3c - a2c + a4c) : '0;
    ent_next[3][1] = wb ? a1c + a2c : '0;
    ent_next[3][2] = wb ? a2c : '0;
    ent_next[3][3] = -a3c - a4c;
    ent_next[3][4] = -a4c;
  end

  always_ff @(posedge clk) begin
    if (rst) j_valid <= 1'b0;
    else if (en) j_valid <= t_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      j_pos <= pos_next;
      j_ent <= ent_next;
      j_rate <= t_rate;
    end
  end

  // rate products
  always_ff @(posedge clk) begin
    if (rst) v_valid <= 1'b0;
    else if (en) v_valid <= j_valid;
  end

  for (genvar r = 0; r < 4; r++) begin : g_row
    for (genvar c = 0; c < 5; c++) begin : g_col
      always_ff @(posedge clk) begin
        if (en) v_prod[r][c] <= j_ent[r][c] * j_rate[c];
      end
    end
    always_comb begin
      vel[r] = VEL_SUM_W'(v_prod[r][0]) + VEL_SUM_W'(v_prod[r][1])
             + VEL_SUM_W'(v_prod[r][2]) + VEL_SUM_W'(v_prod[r][3])
             + VEL_SUM_W'(v_prod[r][4]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) v_pos <= j_pos;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= v_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      result.lx <= sat_pos(v_pos[0]);
      result.ly <= sat_pos(v_pos[1]);
      result.rx <= sat_pos(v_pos[2]);
      result.ry <= sat_pos(v_pos[3]);
      result.lvx <= sat_vel(vel[0]);
      result.lvy <= sat_vel(vel[1]);
      result.rvx <= sat_vel(vel[2]);
      result.rvy <= sat_vel(vel[3]);
    end
  end

endmodule
